// File: rtl/core/multi_service_heartbeat_supervisor_macros.svh
// Assertion macros for the supervisor
`ifndef MULTI_SERVICE_HEARTBEAT_SUPERVISOR_MACROS_SVH
`define MULTI_SERVICE_HEARTBEAT_SUPERVISOR_MACROS_SVH
`ifndef SYNTHESIS
`define MSHS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MSHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MSHS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MSHS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/mshs_pkg.sv
package mshs_pkg;
  localparam int SERVICES = 5;
  localparam int SW = 3;
  localparam int TW = 40;

  // reciprocal of 125 scaled by 2^38, exact for the eighth of a sub-saturation span
  localparam logic [31:0] MS_RECIP = 32'd2199023256;
  // span in microseconds at which the recovery time saturates
  localparam logic [39:0] MS_SAT_US = 40'd16777216000;

  typedef enum logic [1:0] {
    CMD_CHECK = 2'd0, CMD_BEAT = 2'd1, CMD_REPORT = 2'd2, CMD_DEATH = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    MODE_START = 3'd0, MODE_HEALTHY = 3'd1, MODE_DEGRADED = 3'd2,
    MODE_RECOVER = 3'd3, MODE_DOWN = 3'd4
  } mode_t;

  localparam logic [1:0] GRADE_OK = 2'd0;
  localparam logic [1:0] GRADE_WARN = 2'd1;
  localparam logic [1:0] GRADE_FAIL = 2'd2;

  localparam logic [2:0] REG_CPU = 3'd5;
  localparam logic [2:0] REG_IPC = 3'd6;
  localparam logic [2:0] REG_FAIL = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_MOD, ST_DIV, ST_WRITE, ST_EMIT
  } state_t;

  // one service entry of the state memory
  typedef struct packed {
    logic [39:0] last_beat;
    logic [1:0]  grade;
    logic [2:0]  mode;
    logic [15:0] restarts;
    logic [39:0] fault_time;
    logic        fault_seen;
    logic [23:0] rec_time;
    logic        deadline;
    logic [13:0] cpu;
    logic [19:0] ipc;
    logic [7:0]  misses;
  } entry_t;

  // divider control between top and divider
  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;
endpackage

// File: rtl/core/multi_service_heartbeat_supervisor.sv
// Heartbeat, report and death requests: read, modify and write, no result; a bad service id is dropped.
// Check requests: read, modify, divide and write for every service; the divide is skipped if down or start.
// Five result strobes follow on consecutive cycles, the last in the first cycle busy is low again;
// the period divider is bit-serial, and no new request is taken while busy.
// Reset: synchronous; clears the state memory by a pass over every entry, no request taken.
// Results are strobed once and cannot be stalled by the receiver.
`include "multi_service_heartbeat_supervisor_macros.svh"
module multi_service_heartbeat_supervisor (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [39:0] time_us,
  input  logic [2:0]  svc_id,
  input  logic        deadline_met,
  input  logic [13:0] cpu_load,
  input  logic [19:0] ipc_time_us,
  output logic        result_valid,
  output logic [2:0]  out_svc,
  output logic [1:0]  beat_status,
  output logic [2:0]  svc_status,
  output logic        restart_request,
  output logic [7:0]  missed_beats,
  output logic [15:0] restarts_done,
  output logic [23:0] recovery_time_ms,
  output logic [2:0]  system_status,
  output logic [15:0] faults_total,
  output logic [15:0] recoveries_total,
  output logic        last_result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int N = mshs_pkg::SERVICES;

  // configuration
  logic [19:0] period [N];
  logic [13:0] cpu_limit;
  logic [19:0] ipc_limit;
  logic [7:0]  fail_misses;
  logic        cfg_wr;
  logic [2:0]  ridx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign ridx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      period[0] <= 20'd100000;
      if (N > 1) period[1] <= 20'd100000;
      if (N > 2) period[2] <= 20'd200000;
      if (N > 3) period[3] <= 20'd200000;
      if (N > 4) period[4] <= 20'd50000;
      cpu_limit <= 14'd8000;
      ipc_limit <= 20'd5000;
      fail_misses <= 8'd3;
    end else if (cfg_wr) begin
      if (ridx == mshs_pkg::REG_CPU) cpu_limit <= pwdata[13:0];
      else if (ridx == mshs_pkg::REG_IPC) ipc_limit <= pwdata[19:0];
      else if (ridx == mshs_pkg::REG_FAIL) fail_misses <= pwdata[7:0];
      else if (32'(ridx) < N) period[ridx] <= pwdata[19:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (ridx == mshs_pkg::REG_CPU) prdata = 32'(cpu_limit);
    else if (ridx == mshs_pkg::REG_IPC) prdata = 32'(ipc_limit);
    else if (ridx == mshs_pkg::REG_FAIL) prdata = 32'(fail_misses);
    else if (32'(ridx) < N) prdata = 32'(period[ridx]);
  end

  // state memory, one entry per service, registered read
  mshs_pkg::entry_t mem [N];
  mshs_pkg::entry_t rd;
  logic [2:0] addr;
  logic we;
  mshs_pkg::entry_t wd;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wd;
    rd <= mem[addr];
  end

  // controller registers
  mshs_pkg::state_t state, state_next;
  logic [1:0]  r_cmd;
  logic [39:0] r_time;
  logic        r_dl;
  logic [13:0] r_cpu;
  logic [19:0] r_ipc;
  logic [2:0]  idx;
  logic        clr;
  mshs_pkg::entry_t ent;
  logic [N-1:0] restarted;
  logic bad, warn;
  logic [2:0]  sys_mode;
  logic [15:0] fault_cnt, rec_cnt;
  logic [39:0] late;
  logic [39:0] per;
  logic        div_go;
  mshs_pkg::div_ctl_t dctl;
  logic [39:0] quo;
  logic [39:0] div_a, div_b;
  logic [39:0] rec_diff;
  logic [30:0] rec_x;
  logic        rec_sat;
  logic [62:0] rec_prod;
  logic [23:0] rec_ms;

  mshs_divider u_div (
    .clk(clk), .rst(rst), .start(div_go), .dividend(div_a), .divisor(div_b),
    .ctl(dctl), .quotient(quo)
  );

  function automatic logic [15:0] inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  assign per = (period[idx] == 20'd0) ? 40'd1 : 40'(period[idx]);
  assign late = (r_time > rd.last_beat) ? r_time - rd.last_beat : 40'd0;

  // recovery time in ms: divide by 8, then multiply by the reciprocal of 125
  assign rec_diff = (r_time >= rd.fault_time) ? r_time - rd.fault_time : 40'd0;
  assign rec_prod = 63'(rec_x) * 63'(mshs_pkg::MS_RECIP);
  assign rec_ms = rec_sat ? 24'hFFFFFF : rec_prod[61:38];

  // start the divider in the read-result state, for a check of a service that is neither down nor starting
  always_comb begin
    div_go = 1'b0;
    div_a = late;
    div_b = per;
    if (state == mshs_pkg::ST_MOD && r_cmd == mshs_pkg::CMD_CHECK) begin
      div_go = rd.mode != mshs_pkg::MODE_DOWN && rd.mode != mshs_pkg::MODE_START;
    end
  end

  assign busy = state != mshs_pkg::ST_IDLE || clr;

  always_ff @(posedge clk) begin
    if (rst) state <= mshs_pkg::ST_IDLE;
    else state <= state_next;
  end

  // next state; a request for an out-of-range service is taken and dropped
  always_comb begin
    state_next = state;
    unique case (state)
      mshs_pkg::ST_IDLE: begin
        if (start && !clr && (cmd == mshs_pkg::CMD_CHECK || 32'(svc_id) < N))
          state_next = mshs_pkg::ST_READ;
      end
      mshs_pkg::ST_READ:  state_next = mshs_pkg::ST_MOD;
      mshs_pkg::ST_MOD:   state_next = div_go ? mshs_pkg::ST_DIV : mshs_pkg::ST_WRITE;
      mshs_pkg::ST_DIV:   if (!dctl.busy) state_next = mshs_pkg::ST_WRITE;
      mshs_pkg::ST_WRITE: begin
        if (r_cmd != mshs_pkg::CMD_CHECK) state_next = mshs_pkg::ST_IDLE;
        else if (32'(idx) == N - 1) state_next = mshs_pkg::ST_EMIT;
        else state_next = mshs_pkg::ST_READ;
      end
      mshs_pkg::ST_EMIT:  if (32'(idx) == N - 1) state_next = mshs_pkg::ST_IDLE;
      default: state_next = mshs_pkg::ST_IDLE;
    endcase
  end

  // modified entry for write back
  mshs_pkg::entry_t upd;
  logic upd_restart, upd_bad, upd_warn;
  logic [39:0] m;
  logic [7:0] ms8;
  always_comb begin
    upd = ent;
    upd_restart = 1'b0;
    upd_bad = 1'b0;
    upd_warn = 1'b0;
    m = '0;
    ms8 = '0;
    unique case (r_cmd)
      mshs_pkg::CMD_BEAT: begin
        upd.last_beat = r_time;
        upd.misses = '0;
        upd.grade = mshs_pkg::GRADE_OK;
        if (ent.mode == mshs_pkg::MODE_RECOVER || ent.mode == mshs_pkg::MODE_START) begin
          if (ent.fault_seen)
            upd.rec_time = rec_ms;
          upd.mode = mshs_pkg::MODE_HEALTHY;
        end
      end
      mshs_pkg::CMD_REPORT: begin
        upd.deadline = r_dl;
        upd.cpu = r_cpu;
        upd.ipc = r_ipc;
      end
      mshs_pkg::CMD_DEATH: upd.mode = mshs_pkg::MODE_DOWN;
      mshs_pkg::CMD_CHECK: begin
        if (ent.mode == mshs_pkg::MODE_DOWN) begin
          upd_restart = 1'b1;
        end else if (ent.mode == mshs_pkg::MODE_START) begin
          upd_warn = 1'b1;
        end else begin
          m = (late >= (per << 1)) ? quo - 40'd1 : 40'd0;
          ms8 = (m > 40'd255) ? 8'd255 : m[7:0];
          upd.misses = ms8;
          if (ms8 == 8'd0) upd.grade = mshs_pkg::GRADE_OK;
          else if (ms8 < fail_misses) upd.grade = mshs_pkg::GRADE_WARN;
          else upd.grade = mshs_pkg::GRADE_FAIL;
          if (upd.grade == mshs_pkg::GRADE_FAIL) upd_restart = 1'b1;
          else if (ent.mode == mshs_pkg::MODE_RECOVER) upd_warn = 1'b1;
          else if (!ent.deadline || ent.cpu > cpu_limit || ent.ipc > ipc_limit ||
                   upd.grade == mshs_pkg::GRADE_WARN) begin
            upd.mode = mshs_pkg::MODE_DEGRADED;
            upd_warn = 1'b1;
          end else upd.mode = mshs_pkg::MODE_HEALTHY;
        end
        if (upd_restart) begin
          upd_bad = 1'b1;
          upd.fault_time = r_time;
          upd.fault_seen = 1'b1;
          upd.mode = mshs_pkg::MODE_RECOVER;
          upd.grade = mshs_pkg::GRADE_FAIL;
          upd.misses = '0;
          upd.last_beat = r_time;
          upd.restarts = inc16(ent.restarts);
        end
      end
      default: ;
    endcase
  end

  // memory port: clear pass, walk, emit
  always_comb begin
    we = 1'b0;
    wd = upd;
    addr = idx;
    if (clr) begin
      we = 1'b1;
      wd = '0;
      wd.deadline = 1'b1;
    end else if (state == mshs_pkg::ST_WRITE) begin
      we = 1'b1;
    end else if (state == mshs_pkg::ST_IDLE && start) begin
      addr = (cmd == mshs_pkg::CMD_CHECK) ? 3'd0 : svc_id;
    end else if (state == mshs_pkg::ST_WRITE) begin
      addr = idx;
    end
    if (state == mshs_pkg::ST_EMIT) addr = idx;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= 1'b1;
      idx <= '0;
      sys_mode <= mshs_pkg::MODE_START;
      fault_cnt <= '0;
      rec_cnt <= '0;
      result_valid <= 1'b0;
      restarted <= '0;
      bad <= 1'b0;
      warn <= 1'b0;
    end else begin
      result_valid <= state == mshs_pkg::ST_EMIT;
      if (clr) begin
        if (32'(idx) == N - 1) begin
          clr <= 1'b0;
          idx <= '0;
        end else idx <= idx + 3'd1;
      end
      unique case (state)
        mshs_pkg::ST_IDLE: if (start && !clr) begin
          r_cmd <= cmd; r_time <= time_us; r_dl <= deadline_met;
          r_cpu <= cpu_load; r_ipc <= ipc_time_us;
          idx <= (cmd == mshs_pkg::CMD_CHECK) ? 3'd0 : svc_id;
          restarted <= '0; bad <= 1'b0; warn <= 1'b0;
        end
        mshs_pkg::ST_MOD: begin
          ent <= rd;
          rec_x <= rec_diff[33:3];
          rec_sat <= rec_diff >= mshs_pkg::MS_SAT_US;
        end
        mshs_pkg::ST_WRITE: if (r_cmd == mshs_pkg::CMD_CHECK) begin
          restarted[idx] <= upd_restart;
          if (upd_restart) begin
            fault_cnt <= inc16(fault_cnt);
            rec_cnt <= inc16(rec_cnt);
          end
          if (upd_bad) bad <= 1'b1;
          if (upd_warn) warn <= 1'b1;
          if (32'(idx) == N - 1) begin
            idx <= '0;
            sys_mode <= (bad || upd_bad) ? mshs_pkg::MODE_DOWN :
                        ((warn || upd_warn) ? mshs_pkg::MODE_DEGRADED : mshs_pkg::MODE_HEALTHY);
          end else idx <= idx + 3'd1;
        end
        mshs_pkg::ST_EMIT: begin
          out_svc <= idx;
          restart_request <= restarted[idx];
          last_result <= 32'(idx) == N - 1;
          system_status <= (32'(idx) == N - 1) ? sys_mode : 3'd0;
          faults_total <= (32'(idx) == N - 1) ? fault_cnt : 16'd0;
          recoveries_total <= (32'(idx) == N - 1) ? rec_cnt : 16'd0;
          idx <= (32'(idx) == N - 1) ? 3'd0 : idx + 3'd1;
        end
        default: ;
      endcase
    end
  end

  // memory read data is registered and arrives in the cycle after the emit address
  logic emit_d;
  always_ff @(posedge clk) begin
    if (rst) emit_d <= 1'b0;
    else emit_d <= state == mshs_pkg::ST_EMIT;
  end
  assign beat_status = rd.grade;
  assign svc_status = rd.mode;
  assign missed_beats = rd.misses;
  assign restarts_done = rd.restarts;
  assign recovery_time_ms = rd.rec_time;

  // each result strobe follows an emit step
  `MSHS_ASSERT_IMPL(a_emit_sync, clk, rst, result_valid, emit_d)
  `MSHS_ASSERT_IMPL(a_no_start_clear, clk, rst, clr, busy)
  `MSHS_ASSERT_NEXT(a_div_done, clk, rst, div_go, dctl.busy)
  `MSHS_ASSERT_IMPL(a_last_idx, clk, rst, result_valid && last_result, out_svc == 3'(N - 1))
endmodule

// File: rtl/core/mshs_divider.sv
// Restoring divider, one quotient bit per cycle
module mshs_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [mshs_pkg::TW-1:0]   dividend,
  input  logic [mshs_pkg::TW-1:0]   divisor,
  output mshs_pkg::div_ctl_t        ctl,
  output logic [mshs_pkg::TW-1:0]   quotient
);
  logic [mshs_pkg::TW-1:0] rem;
  logic [mshs_pkg::TW-1:0] dvs;
  logic [5:0] cnt;
  logic busy;
  logic [mshs_pkg::TW:0] trial;

  assign trial = {rem, quotient[mshs_pkg::TW-1]} - {1'b0, dvs};
  assign ctl.start = start;
  assign ctl.busy = busy;

  // shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 6'(mshs_pkg::TW);
      rem <= '0;
      quotient <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[mshs_pkg::TW]) begin
        rem <= trial[mshs_pkg::TW-1:0];
        quotient <= {quotient[mshs_pkg::TW-2:0], 1'b1};
      end else begin
        rem <= {rem[mshs_pkg::TW-2:0], quotient[mshs_pkg::TW-1]};
        quotient <= {quotient[mshs_pkg::TW-2:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end
endmodule
